// File: rtl/core/sbda_pkg.sv
// shared constants and types for the signed binary to decimal ascii core
package sbda_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int STEP_BITS   = 4;
   localparam int STEPS       = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int SHIFT_BITS  = STEPS * STEP_BITS;
   localparam int STEP_CNT_W  = $clog2(STEPS);
   // decimal digits of the largest magnitude, floor(n*log10(2)) + 1
   localparam int DIGITS      = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS    = DIGITS * 4;
   localparam int DIGIT_IDX_W = $clog2(DIGITS);
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);
   localparam int CHAR_BITS   = 6;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
   } sbda_entry_type;

   typedef struct packed {
      logic                neg;
      logic [BCD_BITS-1:0] bcd;
   } sbda_bcd_type;

   typedef enum logic [2:0] {
      CV_IDLE = 3'b001,
      CV_RUN  = 3'b010,
      CV_DONE = 3'b100
   } sbda_cv_state_type;

   typedef enum logic [2:0] {
      EM_IDLE  = 3'b001,
      EM_SIGN  = 3'b010,
      EM_DIGIT = 3'b100
   } sbda_em_state_type;

endpackage

// File: rtl/core/sbda_front.sv
// input side: takes a value, splits it into sign and magnitude, pushes it to the queue
module sbda_front import sbda_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         q_full,
   output logic                         q_push,
   output sbda_entry_type               q_entry
);

   logic [VALUE_BITS-1:0] raw;
   logic                  seen_ff;
   logic                  seen_in;

   assign raw       = req_value;
   assign req_stall = q_full || !seen_ff;
   assign q_push    = req_valid && !req_stall;

   // magnitude kept unsigned, so the most negative value needs no special case
   assign q_entry.neg = raw[VALUE_BITS-1];
   assign q_entry.mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

   // hold off the first transaction in the first cycle out of reset
   assign seen_in = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

// File: rtl/core/sbda_queue.sv
// short queue between the front and the converter
module sbda_queue import sbda_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sbda_entry_type push_entry,
   output logic           full,
   output logic           pop_valid,
   input  logic           pop,
   output sbda_entry_type pop_entry
);

   sbda_entry_type        slot_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff;
   logic [QCNT_W-1:0]     count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/sbda_convert.sv
// binary to bcd converter, shift and add-3, STEP_BITS bits per cycle while running
module sbda_convert import sbda_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_pop,
   input  sbda_entry_type in_entry,
   output logic           out_valid,
   input  logic           out_ready,
   output sbda_bcd_type   out_bcd
);

   sbda_cv_state_type       state_ff;
   sbda_cv_state_type       state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff;
   logic [STEP_CNT_W-1:0]   cnt_in;
   logic [SHIFT_BITS-1:0]   shift_ff;
   logic [SHIFT_BITS-1:0]   shift_in;
   logic [BCD_BITS-1:0]     bcd_ff;
   logic [BCD_BITS-1:0]     bcd_in;
   logic                    neg_ff;
   logic                    neg_in;
   logic [SHIFT_BITS-1:0]   step_shift;
   logic [BCD_BITS-1:0]     step_bcd;

   assign in_pop        = (state_ff == CV_IDLE) && in_valid;
   assign out_valid     = (state_ff == CV_DONE);
   assign out_bcd.neg   = neg_ff;
   assign out_bcd.bcd   = bcd_ff;

   // STEP_BITS dependent add-3 and shift passes on four-bit digits
   always_comb begin
      step_bcd   = bcd_ff;
      step_shift = shift_ff;
      for (int k = 0; k < STEP_BITS; k++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (step_bcd[d*4 +: 4] >= 4'd5) begin
               step_bcd[d*4 +: 4] = step_bcd[d*4 +: 4] + 4'd3;
            end
         end
         step_bcd   = {step_bcd[BCD_BITS-2:0], step_shift[SHIFT_BITS-1]};
         step_shift = {step_shift[SHIFT_BITS-2:0], 1'b0};
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         CV_IDLE: begin
            if (in_valid) begin
               state_in = CV_RUN;
               cnt_in   = STEP_CNT_W'(STEPS - 1);
               shift_in = SHIFT_BITS'(in_entry.mag);
               bcd_in   = '0;
               neg_in   = in_entry.neg;
            end
         end
         CV_RUN: begin
            shift_in = step_shift;
            bcd_in   = step_bcd;
            if (cnt_ff == '0) begin
               state_in = CV_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         CV_DONE: begin
            if (out_ready) begin
               state_in = CV_IDLE;
            end
         end
         default: begin
            state_in = CV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      neg_ff   <= neg_in;
   end

endmodule

// File: rtl/core/sbda_emit.sv
// character emitter: sign, then digits from the top nonzero one down, into an output register
module sbda_emit import sbda_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sbda_bcd_type         in_bcd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAR_BITS-1:0] rsp_character,
   output logic                 rsp_last
);

   sbda_em_state_type        state_ff;
   sbda_em_state_type        state_in;
   logic [DIGIT_IDX_W-1:0]   pos_ff;
   logic [DIGIT_IDX_W-1:0]   pos_in;
   logic [BCD_BITS-1:0]      bcd_ff;
   logic [BCD_BITS-1:0]      bcd_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [CHAR_BITS-1:0]     rsp_character_ff;
   logic [CHAR_BITS-1:0]     rsp_character_in;
   logic                     rsp_last_ff;
   logic                     rsp_last_in;
   logic [DIGIT_IDX_W-1:0]   top_pos;
   logic [3:0]               cur_digit;
   logic                     slot_free;

   assign in_ready      = (state_ff == EM_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;
   assign slot_free     = !rsp_valid_ff || !rsp_stall;
   assign cur_digit     = bcd_ff[pos_ff*4 +: 4];

   // highest nonzero digit, zero when the whole value is zero
   always_comb begin
      top_pos = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (in_bcd.bcd[d*4 +: 4] != 4'd0) begin
            top_pos = DIGIT_IDX_W'(d);
         end
      end
   end

   always_comb begin
      state_in         = state_ff;
      pos_in           = pos_ff;
      bcd_in           = bcd_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (state_ff)
         EM_IDLE: begin
            if (in_valid) begin
               state_in = in_bcd.neg ? EM_SIGN : EM_DIGIT;
               pos_in   = top_pos;
               bcd_in   = in_bcd.bcd;
            end
         end
         EM_SIGN: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = EM_DIGIT;
            end
         end
         EM_DIGIT: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_ZERO + {2'b00, cur_digit};
               rsp_last_in      = (pos_ff == '0);
               if (pos_ff == '0) begin
                  state_in = EM_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      bcd_ff           <= bcd_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

endmodule

// File: rtl/core/signed_binary_to_decimal_ascii_core.sv
// top level of the signed binary to decimal ascii core
// usage:
//   req channel: one signed two's complement value per transaction, taken at a
//   rising edge with req_valid high and req_stall low
//   rsp channel: one ascii character per transaction, most significant first;
//   a minus sign leads negative values, no leading zeros, zero gives '0';
//   rsp_last marks the final character of each number
//   path: a request passes the queue slot, the converter's idle, run and done
//   states and the emitter's load state and output register before its first
//   character shows on rsp, with an idle output
//   rate: set by the slower of the character emitter, one character per cycle
//   while rsp is not stalled plus a load state, and the bcd converter (steps
//   of four shift and add-3 passes), which works on the next number meanwhile
//   a two entry queue behind the front lets requests arrive while the
//   converter is busy
//   reset clears the queue, the converter and the output valid; req_stall is
//   held high in the first cycle after reset
//   a stalled rsp holds its character; the emitter waits and the queue fills
//   until req_stall rises
module signed_binary_to_decimal_ascii_core import sbda_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CHAR_BITS-1:0]         rsp_character,
   output logic                         rsp_last
);

   // front to queue
   logic           q_full;
   logic           q_push;
   sbda_entry_type q_push_entry;

   // queue to converter
   logic           q_valid;
   logic           q_pop;
   sbda_entry_type q_pop_entry;

   // converter to emitter
   logic           cv_valid;
   logic           em_ready;
   sbda_bcd_type   cv_bcd;

   sbda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   sbda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry)
   );

   sbda_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_pop    (q_pop),
      .in_entry  (q_pop_entry),
      .out_valid (cv_valid),
      .out_ready (em_ready),
      .out_bcd   (cv_bcd)
   );

   sbda_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cv_valid),
      .in_ready      (em_ready),
      .in_bcd        (cv_bcd),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // a minus sign is never the final character of a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last");

   // only a minus sign or a decimal digit leaves the block
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS) ||
                    ((rsp_character >= CHAR_ZERO) && (rsp_character <= CHAR_ZERO + 6'd9)))
      else $error("character out of range");

   // after a converter handoff the emitter is busy and the converter no longer valid in the next cycle
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      cv_valid && em_ready |=> !em_ready && !cv_valid)
      else $error("converter handoff lost");

   // nothing enters the queue while it is full
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

endmodule
